FILE: hdl/rewd_pkg.sv
package rewd_pkg;

    // log2 result: 5 integer bits (msb index) and LOG_FRAC fraction bits
    localparam int LOG_FRAC = 24;
    localparam int LOG_W    = 5 + LOG_FRAC;
    localparam int LOG_LAT  = LOG_FRAC + 1;

    // ln2 in Q0.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // quotient bits kept below the overflow check, and divider latency
    localparam int QB      = 33;
    localparam int DIV_LAT = QB + 2;

    localparam int LMAG_W = 30;
    localparam int EMAG_W = 63;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_XZERO = 2'd1;
    localparam logic [1:0] ST_YZERO = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef struct packed {
        logic [31:0] x;
        logic        last;
        logic        xz;
        logic        yz;
        logic        wneg;
    } side_t;

    typedef struct packed {
        logic              lneg;
        logic [LMAG_W-1:0] lmag;
        logic [EMAG_W-1:0] emag;
    } lres_t;

    typedef struct packed {
        logic [31:0] entropy;
        logic [31:0] grad_x;
        logic [31:0] grad_y;
        logic [31:0] hess_xx;
        logic [31:0] hess_xy;
        logic [31:0] hess_yy;
        logic [1:0]  status;
        logic        last;
    } res_t;

    // {overflow, value}: clamp a sign/magnitude to signed 32 bits
    function automatic logic [32:0] sat32(input logic neg, input logic [63:0] mag,
                                          input logic big);
        logic [63:0] ng;
        logic [32:0] r;
        ng = 64'd0 - mag;
        if (neg) begin
            if (big || mag > 64'h8000_0000) begin
                r = {1'b1, 32'h8000_0000};
            end else begin
                r = {1'b0, ng[31:0]};
            end
        end else begin
            if (big || mag > 64'h7FFF_FFFF) begin
                r = {1'b1, 32'h7FFF_FFFF};
            end else begin
                r = {1'b0, mag[31:0]};
            end
        end
        return r;
    endfunction

endpackage

FILE: hdl/rewd_in_if.sv
interface rewd_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        x_value;
    logic [31:0]        y_value;
    logic signed [31:0] weight;
    logic               last_in;

    modport source (output valid, x_value, y_value, weight, last_in, input ready);
    modport sink   (input valid, x_value, y_value, weight, last_in, output ready);
endinterface

FILE: hdl/rewd_out_if.sv
interface rewd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] entropy;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] hess_xx;
    logic signed [31:0] hess_xy;
    logic signed [31:0] hess_yy;
    logic [1:0]         status;
    logic               last_out;

    modport source (output valid, entropy, grad_x, grad_y, hess_xx, hess_xy, hess_yy,
                    status, last_out, input ready);
    modport sink   (input valid, entropy, grad_x, grad_y, hess_xx, hess_xy, hess_yy,
                    status, last_out, output ready);
endinterface

FILE: hdl/rewd_log2.sv
// Pipelined log2: normalize stage, then one squaring per stage.
module rewd_log2 import rewd_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [31:0]      v,
    output logic [LOG_W-1:0] lg
);

    logic [4:0]          msb;
    logic [4:0]          n_reg [0:LOG_FRAC];
    logic [31:0]         m_reg [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] f_reg [0:LOG_FRAC];

    always_comb
    begin
        msb = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                msb = 5'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0] <= msb;
            m_reg[0] <= v << (5'd31 - msb);
            f_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_sq
        logic [63:0]         sq;
        logic [32:0]         t;
        logic [31:0]         m_next;
        logic [LOG_FRAC-1:0] f_next;

        assign sq     = 64'(m_reg[k-1]) * 64'(m_reg[k-1]);
        assign t      = sq[63:31];
        assign m_next = t[32] ? t[32:1] : t[31:0];
        assign f_next = f_reg[k-1] | (LOG_FRAC'(t[32]) << (LOG_FRAC - k));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k] <= n_reg[k-1];
                m_reg[k] <= m_next;
                f_reg[k] <= f_next;
            end
        end
    end

    assign lg = {n_reg[LOG_FRAC], f_reg[LOG_FRAC]};

endmodule

FILE: hdl/rewd_div.sv
// Pipelined restoring divider, one quotient bit per stage, rounded half up.
// big flags a quotient of 2^QB or more.
module rewd_div import rewd_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = 32
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QB:0]   quo,
    output logic          big
);

    localparam int HW = NW - QB;

    logic [HW-1:0] hi;
    logic          big_next;
    logic [DW-1:0] rem_reg [0:QB];
    logic [QB-1:0] low_reg [0:QB];
    logic [QB-1:0] q_reg   [0:QB];
    logic [DW-1:0] d_reg   [0:QB];
    logic          big_reg [0:QB];
    logic [QB:0]   quo_reg;
    logic          bigo_reg;
    logic          rnd;

    assign hi       = num[NW-1:QB];
    assign big_next = {{DW{1'b0}}, hi} >= {{HW{1'b0}}, den};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(hi);
            low_reg[0] <= num[QB-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= den;
            big_reg[0] <= big_next;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [DW:0]   sh;
        logic [DW:0]   df;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QB-1:0] q_next;

        assign sh       = {rem_reg[k-1], low_reg[k-1][QB-k]};
        assign df       = sh - {1'b0, d_reg[k-1]};
        assign ge       = sh >= {1'b0, d_reg[k-1]};
        assign rem_next = ge ? df[DW-1:0] : sh[DW-1:0];
        assign q_next   = q_reg[k-1] | (QB'(ge) << (QB - k));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= low_reg[k-1];
                q_reg[k]   <= q_next;
                d_reg[k]   <= d_reg[k-1];
                big_reg[k] <= big_reg[k-1];
            end
        end
    end

    assign rnd = {rem_reg[QB], 1'b0} >= {1'b0, d_reg[QB]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg  <= {1'b0, q_reg[QB]} + (QB+1)'(rnd);
            bigo_reg <= big_reg[QB];
        end
    end

    assign quo = quo_reg;
    assign big = bigo_reg;

endmodule

FILE: hdl/relative_entropy_with_derivatives.sv
// Channel   Dir  Payload                                                  Handshake
// in_ch     in   x_value, y_value, weight, last_in                        valid/ready
// out_ch    out  entropy, grad_x, grad_y, hess_xx, hess_xy, hess_yy,      valid/ready
//                status, last_out
//
// One item per cycle enters while in_ch.ready is high; a result passes through
// the 33-bit quotient dividers (one bit per stage) plus input,
// product, check, rounding and output stages.
// rst_n (async, low) clears all valid bits and the output/skid registers.
// Downstream stalls fill a one-item skid; the whole pipeline then freezes,
// in_ch.ready drops, and nothing is lost or repeated.
module relative_entropy_with_derivatives import rewd_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    rewd_in_if.sink    in_ch,
    rewd_out_if.source out_ch
);

    localparam int NW1    = 32 + FRAC_BITS;      // x<<F, w<<F
    localparam int NW2    = 64 + FRAC_BITS;      // (w*x)<<F
    localparam int P_LAST = 1 + DIV_LAT;         // stage where quotients land
    localparam int P_D    = LOG_LAT + 1;         // log difference
    localparam int P_MUL  = LOG_LAT + 2;         // times ln2
    localparam int P_LM   = LOG_LAT + 3;         // rounded ln(x/y)
    localparam int P_EP   = LOG_LAT + 4;         // x * ln(x/y)
    localparam int P_EM   = LOG_LAT + 5;         // rounded entropy magnitude
    localparam int S_SH   = LOG_FRAC + 32 - FRAC_BITS;
    localparam logic [61:0] HALF_L = 62'd1 << (S_SH - 1);
    localparam logic [62:0] HALF_E = 63'd1 << (FRAC_BITS - 1);
    localparam logic [63:0] ONE    = 64'd1 << FRAC_BITS;

    logic  adv;
    logic  v_reg    [0:P_LAST];
    side_t side_reg [0:P_LAST];
    side_t side_next;

    // stage 0/1 operand registers
    logic [31:0] w_bits;
    logic [31:0] y0_reg, w0_reg;
    logic [31:0] y1_reg, w1_reg;
    logic [63:0] wx1_reg, yy1_reg;

    // log chain
    logic [LOG_W-1:0]  lgx, lgy;
    logic [LOG_W:0]    dd;
    logic              dneg_reg, mneg_reg, lmneg_reg, epneg_reg;
    logic [LOG_W-1:0]  dmag_reg;
    logic [60:0]       prod_reg;
    logic [61:0]       lsum;
    logic [61:0]       lsh;
    logic [LMAG_W-1:0] lmag_reg, eplm_reg;
    logic [61:0]       ep_reg;
    logic [62:0]       esum;
    lres_t             lres_reg [P_EM:P_LAST];
    lres_t             lres_next;

    // quotients
    logic [QB:0] q_gy, q_xx, q_xy, q_yy;
    logic        b_gy, b_xx, b_xy, b_yy;

    // result assembly
    side_t       sd;
    lres_t       lr;
    logic [63:0] lm64;
    logic [32:0] s_ent, s_gx, s_gy, s_xx, s_xy, s_yy;
    logic        ovf;
    res_t        res;
    res_t        out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;
    logic        out_fire;

    assign adv         = !skid_valid_reg;
    assign in_ch.ready = adv;

    // -------- stage 0: capture, weight to sign/magnitude
    assign w_bits         = in_ch.weight;
    assign side_next.x    = in_ch.x_value;
    assign side_next.last = in_ch.last_in;
    assign side_next.xz   = (in_ch.x_value == 32'd0);
    assign side_next.yz   = (in_ch.y_value == 32'd0);
    assign side_next.wneg = w_bits[31];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= P_LAST; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end else if (adv)
        begin
            v_reg[0] <= in_ch.valid;
            for (int k = 1; k <= P_LAST; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k <= P_LAST; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            y0_reg  <= in_ch.y_value;
            w0_reg  <= w_bits[31] ? (32'd0 - w_bits) : w_bits;
            // stage 1: divider operands, and the products for hess_yy
            y1_reg  <= y0_reg;
            w1_reg  <= w0_reg;
            wx1_reg <= 64'(w0_reg) * 64'(side_reg[0].x);
            yy1_reg <= 64'(y0_reg) * 64'(y0_reg);
        end
    end

    // -------- logarithms, aligned with stage LOG_LAT
    rewd_log2 u_logx (.clk(clk), .en(adv), .v(side_reg[0].x), .lg(lgx));
    rewd_log2 u_logy (.clk(clk), .en(adv), .v(y0_reg),        .lg(lgy));

    assign dd   = {1'b0, lgx} - {1'b0, lgy};
    assign lsum = {1'b0, prod_reg} + HALF_L;
    assign lsh  = lsum >> S_SH;
    assign esum = {1'b0, ep_reg} + HALF_E;

    assign lres_next.lneg = epneg_reg;
    assign lres_next.lmag = eplm_reg;
    assign lres_next.emag = esum >> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // P_D: sign and magnitude of log2(x) - log2(y)
            dneg_reg  <= dd[LOG_W];
            dmag_reg  <= dd[LOG_W] ? LOG_W'(~dd + 1'b1) : dd[LOG_W-1:0];
            // P_MUL
            mneg_reg  <= dneg_reg;
            prod_reg  <= 61'(dmag_reg) * 61'(LN2_Q32);
            // P_LM: ln(x/y) rounded half away from zero
            lmneg_reg <= mneg_reg;
            lmag_reg  <= lsh[LMAG_W-1:0];
            // P_EP
            epneg_reg <= lmneg_reg;
            eplm_reg  <= lmag_reg;
            ep_reg    <= 62'(side_reg[P_LM].x) * 62'(lmag_reg);
            // P_EM onward: hold until the quotients arrive
            lres_reg[P_EM] <= lres_next;
            for (int k = P_EM + 1; k <= P_LAST; k++)
            begin
                lres_reg[k] <= lres_reg[k-1];
            end
        end
    end

    // -------- dividers, fed from stage 1, land at P_LAST
    rewd_div #(.NW(NW1), .DW(32)) u_div_gy (
        .clk(clk), .en(adv), .num({side_reg[1].x, {FRAC_BITS{1'b0}}}), .den(y1_reg),
        .quo(q_gy), .big(b_gy));
    rewd_div #(.NW(NW1), .DW(32)) u_div_xx (
        .clk(clk), .en(adv), .num({w1_reg, {FRAC_BITS{1'b0}}}), .den(side_reg[1].x),
        .quo(q_xx), .big(b_xx));
    rewd_div #(.NW(NW1), .DW(32)) u_div_xy (
        .clk(clk), .en(adv), .num({w1_reg, {FRAC_BITS{1'b0}}}), .den(y1_reg),
        .quo(q_xy), .big(b_xy));
    rewd_div #(.NW(NW2), .DW(64)) u_div_yy (
        .clk(clk), .en(adv), .num({wx1_reg, {FRAC_BITS{1'b0}}}), .den(yy1_reg),
        .quo(q_yy), .big(b_yy));

    // -------- saturation and status
    assign sd   = side_reg[P_LAST];
    assign lr   = lres_reg[P_LAST];
    assign lm64 = 64'(lr.lmag);

    always_comb
    begin
        s_ent = sat32(lr.lneg && (lr.emag != '0), {1'b0, lr.emag}, 1'b0);
        if (lr.lneg)
        begin
            if (lm64 > ONE)
            begin
                s_gx = sat32(1'b1, lm64 - ONE, 1'b0);
            end else begin
                s_gx = sat32(1'b0, ONE - lm64, 1'b0);
            end
        end else begin
            s_gx = sat32(1'b0, lm64 + ONE, 1'b0);
        end
        s_gy = sat32(1'b1, 64'(q_gy), b_gy);
        s_xx = sat32(sd.wneg, 64'(q_xx), b_xx);
        s_xy = sat32(!sd.wneg, 64'(q_xy), b_xy);
        s_yy = sat32(sd.wneg, 64'(q_yy), b_yy);
        ovf  = s_ent[32] | s_gx[32] | s_gy[32] | s_xx[32] | s_xy[32] | s_yy[32];

        res.last = sd.last;
        if (sd.xz || sd.yz)
        begin
            res.entropy = '0;
            res.grad_x  = '0;
            res.grad_y  = '0;
            res.hess_xx = '0;
            res.hess_xy = '0;
            res.hess_yy = '0;
            res.status  = sd.xz ? ST_XZERO : ST_YZERO;
        end else begin
            res.entropy = s_ent[31:0];
            res.grad_x  = s_gx[31:0];
            res.grad_y  = s_gy[31:0];
            res.hess_xx = s_xx[31:0];
            res.hess_xy = s_xy[31:0];
            res.hess_yy = s_yy[31:0];
            res.status  = ovf ? ST_SAT : ST_OK;
        end
    end

    // -------- output register with one-item skid
    assign out_fire = out_valid_reg && out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_reg        <= '0;
            skid_reg       <= '0;
        end else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (v_reg[P_LAST])
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_reg       <= res;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.entropy  = $signed(out_reg.entropy);
    assign out_ch.grad_x   = $signed(out_reg.grad_x);
    assign out_ch.grad_y   = $signed(out_reg.grad_y);
    assign out_ch.hess_xx  = $signed(out_reg.hess_xx);
    assign out_ch.hess_xy  = $signed(out_reg.hess_xy);
    assign out_ch.hess_yy  = $signed(out_reg.hess_yy);
    assign out_ch.status   = out_reg.status;
    assign out_ch.last_out = out_reg.last;

    // -------- checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while output register is empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ch.ready))
        else $error("skid filled without an output stall");

    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.status == ST_XZERO || out_reg.status == ST_YZERO)
        |-> out_reg.entropy == '0 && out_reg.grad_x == '0 && out_reg.hess_yy == '0)
        else $error("zero operand with nonzero result");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == ST_SAT
        |-> out_reg.entropy == 32'h7FFF_FFFF || out_reg.entropy == 32'h8000_0000
         || out_reg.grad_x == 32'h7FFF_FFFF || out_reg.grad_x == 32'h8000_0000
         || out_reg.grad_y == 32'h8000_0000
         || out_reg.hess_xx == 32'h7FFF_FFFF || out_reg.hess_xx == 32'h8000_0000
         || out_reg.hess_xy == 32'h7FFF_FFFF || out_reg.hess_xy == 32'h8000_0000
         || out_reg.hess_yy == 32'h7FFF_FFFF || out_reg.hess_yy == 32'h8000_0000)
        else $error("saturation status without a clamped field");

endmodule
